// ===== rtl/aabb_pkg.sv =====
// Shared types, sizes and codes for the box pair overlap finder.
package aabb_pkg;

	// Store size and derived widths
	localparam int MAX_BOXES = 64;
	localparam int IDX_W     = $clog2(MAX_BOXES);
	localparam int CNT_W     = $clog2(MAX_BOXES + 1);

	// Command queue between front and back
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	// Result queue at the output
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// Operation codes of an input item
	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_ADD   = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [15:0]        entity_id;
		logic               alive;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic [30:0]        width;
		logic [30:0]        height;
	} in_item_t;

	typedef struct packed {
		logic [15:0] earlier_entity;
		logic [15:0] newer_entity;
		logic        overflow;
		logic        last;
	} result_t;

	// One stored box
	typedef struct packed {
		logic [15:0]        id;
		logic               live;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        w;
		logic [30:0]        h;
	} box_t;

	typedef enum logic [1:0] {
		CMD_STORE,
		CMD_SCAN,
		CMD_OVERFLOW
	} cmd_kind_e;

	// Classified work handed from front to back
	typedef struct packed {
		cmd_kind_e         kind;
		logic [IDX_W-1:0]  slot;
		box_t              box;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} back_state_e;

endpackage

// ===== rtl/aabb_front.sv =====
// Front end: accepts items, tracks the box count, classifies and queues commands.
module aabb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  aabb_pkg::in_item_t  item,
	output logic                cmd_valid,
	output aabb_pkg::cmd_t      cmd,
	input  logic                cmd_pop
);

	logic [aabb_pkg::CNT_W-1:0]     count_q;
	logic [aabb_pkg::CMD_CNT_W-1:0] q_cnt_q;
	logic [aabb_pkg::CMD_PTR_W-1:0] wr_ptr_q;
	logic [aabb_pkg::CMD_PTR_W-1:0] rd_ptr_q;
	aabb_pkg::cmd_t                 q_mem_q [aabb_pkg::CMD_DEPTH];
	aabb_pkg::cmd_t                 new_cmd;
	logic                           accept;
	logic                           enq;
	logic                           store_full;

	assign full      = (q_cnt_q == aabb_pkg::CMD_CNT_W'(aabb_pkg::CMD_DEPTH));
	assign cmd_valid = (q_cnt_q != '0);
	assign cmd       = q_mem_q[rd_ptr_q];
	assign accept    = push && !full;
	assign enq       = accept && (item.operation == aabb_pkg::OP_ADD);
	assign store_full = (count_q == aabb_pkg::CNT_W'(aabb_pkg::MAX_BOXES));

	// Classify an add-box item against the current fill of the store
	always_comb begin
		new_cmd.slot   = count_q[aabb_pkg::IDX_W-1:0];
		new_cmd.box.id = item.entity_id;
		new_cmd.box.live = item.alive;
		new_cmd.box.cx = item.center_x;
		new_cmd.box.cy = item.center_y;
		new_cmd.box.w  = item.width;
		new_cmd.box.h  = item.height;
		if (store_full) begin
			new_cmd.kind = aabb_pkg::CMD_OVERFLOW;
		end else if (!item.alive || count_q == '0) begin
			new_cmd.kind = aabb_pkg::CMD_STORE;
		end else begin
			new_cmd.kind = aabb_pkg::CMD_SCAN;
		end
	end

	// Track the number of stored boxes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (item.operation == aabb_pkg::OP_CLEAR) begin
				count_q <= '0;
			end else if (!store_full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Command queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q  <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !cmd_pop) begin
				q_cnt_q <= q_cnt_q + 1'b1;
			end else if (!enq && cmd_pop) begin
				q_cnt_q <= q_cnt_q - 1'b1;
			end
		end
	end

	// Command queue storage
	always_ff @(posedge clk) begin
		if (enq) begin
			q_mem_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

// ===== rtl/aabb_res_fifo.sv =====
// Result queue: holds finished results until the consumer takes them.
module aabb_res_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  aabb_pkg::result_t              wr_data,
	input  logic                           rd_en,
	output logic                           empty,
	output aabb_pkg::result_t              head,
	output logic [aabb_pkg::OUT_CNT_W-1:0] count
);

	aabb_pkg::result_t              mem_q [aabb_pkg::OUT_DEPTH];
	logic [aabb_pkg::OUT_PTR_W-1:0] wr_ptr_q;
	logic [aabb_pkg::OUT_PTR_W-1:0] rd_ptr_q;
	logic [aabb_pkg::OUT_CNT_W-1:0] cnt_q;
	logic                           do_rd;

	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];
	assign count = cnt_q;
	assign do_rd = rd_en && !empty;

	// Advance pointers and fill on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && do_rd) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/aabb_back.sv =====
// Back end: box memory, scan sequencer, overlap pipeline and result marking.
module aabb_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  aabb_pkg::cmd_t                 cmd,
	output logic                           cmd_pop,
	output logic                           res_push,
	output aabb_pkg::result_t              res_data,
	input  logic [aabb_pkg::OUT_CNT_W-1:0] res_count
);

	aabb_pkg::back_state_e       state_q;
	aabb_pkg::back_state_e       state_d;
	aabb_pkg::box_t              mem [aabb_pkg::MAX_BOXES];
	aabb_pkg::box_t              cur_q;
	logic [aabb_pkg::IDX_W-1:0]  scan_idx_q;
	logic [aabb_pkg::IDX_W-1:0]  scan_end_q;

	logic                        v_s1;
	aabb_pkg::box_t              rd_s1;
	logic                        v_s2;
	logic [15:0]                 id_s2;
	logic                        live_s2;
	logic [32:0]                 adx_s2;
	logic [32:0]                 ady_s2;
	logic [31:0]                 sw_s2;
	logic [31:0]                 sh_s2;
	logic                        v_s3;
	logic                        hit_s3;
	logic [15:0]                 id_s3;
	logic                        pend_v_q;
	logic [15:0]                 pend_id_q;

	logic                        mem_we;
	logic                        issue;
	logic                        flush;
	logic                        ovf_push;
	logic                        hit_push;
	logic                        credit_ok;
	logic                        room;
	logic [aabb_pkg::OUT_CNT_W:0] need;
	logic [32:0]                 dx;
	logic [32:0]                 dy;

	assign room = (res_count < aabb_pkg::OUT_CNT_W'(aabb_pkg::OUT_DEPTH));

	// Room for everything in flight, this read and the final flush
	always_comb begin
		need = {1'b0, res_count}
			+ (aabb_pkg::OUT_CNT_W + 1)'(v_s1)
			+ (aabb_pkg::OUT_CNT_W + 1)'(v_s2)
			+ (aabb_pkg::OUT_CNT_W + 1)'(v_s3)
			+ (aabb_pkg::OUT_CNT_W + 1)'(2);
		credit_ok = (need <= (aabb_pkg::OUT_CNT_W + 1)'(aabb_pkg::OUT_DEPTH));
	end

	// Next state and sequencer controls
	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		mem_we   = 1'b0;
		issue    = 1'b0;
		flush    = 1'b0;
		ovf_push = 1'b0;
		unique case (state_q)
			aabb_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						aabb_pkg::CMD_STORE: begin
							cmd_pop = 1'b1;
							mem_we  = 1'b1;
						end
						aabb_pkg::CMD_SCAN: begin
							cmd_pop = 1'b1;
							mem_we  = 1'b1;
							state_d = aabb_pkg::ST_SCAN;
						end
						aabb_pkg::CMD_OVERFLOW: begin
							if (room) begin
								cmd_pop  = 1'b1;
								ovf_push = 1'b1;
							end
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			aabb_pkg::ST_SCAN: begin
				if (credit_ok) begin
					issue = 1'b1;
					if (scan_idx_q == scan_end_q) begin
						state_d = aabb_pkg::ST_DRAIN;
					end
				end
			end
			aabb_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3 && room) begin
					flush   = pend_v_q;
					state_d = aabb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aabb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aabb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Box memory: write the new box, read one stored box per cycle while the scan issues
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cmd.slot] <= cmd.box;
		end
		if (issue) begin
			rd_s1 <= mem[scan_idx_q];
		end
	end

	// Hold the new box and the scan range
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cur_q      <= cmd.box;
			scan_idx_q <= '0;
			scan_end_q <= cmd.slot - 1'b1;
		end else if (issue) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
	end

	// Centre distance per axis
	always_comb begin
		dx = {rd_s1.cx[31], rd_s1.cx} - {cur_q.cx[31], cur_q.cx};
		dy = {rd_s1.cy[31], rd_s1.cy} - {cur_q.cy[31], cur_q.cy};
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 2: absolute distances and summed sizes
	always_ff @(posedge clk) begin
		id_s2   <= rd_s1.id;
		live_s2 <= rd_s1.live;
		adx_s2  <= dx[32] ? (~dx + 33'd1) : dx;
		ady_s2  <= dy[32] ? (~dy + 33'd1) : dy;
		sw_s2   <= {1'b0, rd_s1.w} + {1'b0, cur_q.w};
		sh_s2   <= {1'b0, rd_s1.h} + {1'b0, cur_q.h};
	end

	// Stage 3: overlap on both axes with a live stored box, touching edges included
	always_ff @(posedge clk) begin
		id_s3  <= id_s2;
		hit_s3 <= live_s2
			&& ({adx_s2, 1'b0} <= {2'b00, sw_s2})
			&& ({ady_s2, 1'b0} <= {2'b00, sh_s2});
	end

	// Hold the latest hit back until it is known whether it is the last
	assign hit_push = v_s3 && hit_s3 && pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (v_s3 && hit_s3) begin
			pend_v_q <= 1'b1;
		end else if (flush) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && hit_s3) begin
			pend_id_q <= id_s3;
		end
	end

	// Result transfer into the output queue
	assign res_push = ovf_push || flush || hit_push;

	always_comb begin
		if (ovf_push) begin
			res_data.earlier_entity = '0;
			res_data.newer_entity   = cmd.box.id;
			res_data.overflow       = 1'b1;
			res_data.last           = 1'b1;
		end else begin
			res_data.earlier_entity = pend_id_q;
			res_data.newer_entity   = cur_q.id;
			res_data.overflow       = 1'b0;
			res_data.last           = flush;
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> room)
		else $error("result transfer into a full queue");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aabb_pkg::ST_IDLE) |-> !(v_s1 || v_s2 || v_s3 || pend_v_q))
		else $error("work left in flight while idle");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aabb_pkg::ST_SCAN) |-> (scan_idx_q <= scan_end_q))
		else $error("scan index past the end of the range");

	a_single_push: assert property (@(posedge clk) disable iff (!arst_n)
		flush |-> !(v_s3 || ovf_push))
		else $error("final flush collides with another result");

endmodule

// ===== rtl/aabb_pair_overlap_finder_unit.sv =====
// Top level of the box pair overlap finder: front, back and result queue.
// Usage: push a start-frame item to empty the store, then one add-box item per
// entity; every live box is checked against all live boxes already stored and
// each overlapping pair comes out as (earlier id, newer id), the final pair of
// an item flagged last. The front takes an item whenever it is not full and
// queues up to two add-box commands. In the back, a dead box, the first box of
// a frame, or an overflow needs no scan; a live box added after stored boxes
// is scanned through the single read port of the box memory, which streams one
// stored box per cycle, while the result queue has room, into a three-stage
// compare pipeline. Start-frame items cost the back nothing. Results leave
// through an eight-entry queue, one per cycle; the scan only issues a read when
// the queue has room for every result still in flight, so a consumer that
// stalls slows the scan once more than three results wait in that queue.
module aabb_pair_overlap_finder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  aabb_pkg::in_item_t item,
	input  logic               pop,
	output logic               empty,
	output aabb_pkg::result_t  result
);

	logic                           cmd_valid;
	aabb_pkg::cmd_t                 cmd;
	logic                           cmd_pop;
	logic                           res_push;
	aabb_pkg::result_t              res_data;
	logic [aabb_pkg::OUT_CNT_W-1:0] res_count;

	aabb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	aabb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_count (res_count)
	);

	aabb_res_fifo u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.rd_en   (pop),
		.empty   (empty),
		.head    (result),
		.count   (res_count)
	);

endmodule
